// ===== rtl/mmrt_pkg.sv =====
// Shared constants, entry layout and controller/datapath types for the region table.
package mmrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned PS              = 12;        // page shift
  localparam int unsigned PN_W            = 64 - PS;   // page number / page count width

  // Actions
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_E820  = 3'd1;
  localparam logic [2:0] ACT_ADD   = 3'd2;
  localparam logic [2:0] ACT_ALLOC = 3'd3;
  localparam logic [2:0] ACT_CEIL  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // Region kinds
  localparam logic [3:0] KIND_RESERVED = 4'd0;
  localparam logic [3:0] KIND_RT_CODE  = 4'd5;
  localparam logic [3:0] KIND_RT_DATA  = 4'd6;
  localparam logic [3:0] KIND_FREE     = 4'd7;
  localparam logic [3:0] KIND_ACPI     = 4'd9;
  localparam logic [3:0] KIND_NVS      = 4'd10;

  // Firmware range types
  localparam logic [31:0] FW_MEMORY = 32'd1;
  localparam logic [31:0] FW_ACPI   = 32'd3;
  localparam logic [31:0] FW_NVS    = 32'd4;

  localparam logic [63:0] ATTR_UC       = 64'h1;
  localparam logic [63:0] ATTR_WB       = 64'h8;
  localparam logic [63:0] LOW_LIMIT     = 64'h0000_0000_0010_0000;
  localparam logic [63:0] HIGH_LIMIT    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] CEILING_RESET = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]      kind;
    logic [63:0]     start;
    logic [PN_W-1:0] pages;
    logic [63:0]     attr;
  } entry_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_CLEAR, DP_PREP1, DP_PREP2, DP_SCAN_INIT, DP_EVA, DP_EVB,
    DP_P1_ACC, DP_SCAN_RST, DP_P2_SLOT, DP_P2_TAIL, DP_PUSH_NEW, DP_AL_ACC, DP_AL_REM,
    DP_AL_AT, DP_AL_SPLIT, DP_AL_PUSH, DP_AL_EXACT, DP_CEIL_ACC, DP_RD_IDX, DP_RD_OUT,
    DP_SET_FULL, DP_SET_NOSPACE, DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    logic [2:0] action;
    logic       scan_end;
    logic       zero_pages;
    logic       exact;
    logic       tail;
    logic       brk;
    logic       add_full;
    logic       found;
    logic       alloc_exact;
    logic       tab_full;
  } dp_sts_t;

endpackage

// ===== rtl/mmrt_if.sv =====
// Request and response channel interfaces of the region table.
interface mmrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] base_address;
  logic [63:0] range_length;
  logic [31:0] e820_kind;
  logic [3:0]  mem_kind;
  logic [51:0] page_count;
  logic [63:0] attribute;
  logic [5:0]  entry_index;

  modport source (output valid, action, base_address, range_length, e820_kind, mem_kind,
                  page_count, attribute, entry_index, input ready);
  modport sink   (input valid, action, base_address, range_length, e820_kind, mem_kind,
                  page_count, attribute, entry_index, output ready);
endinterface

interface mmrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] alloc_address;
  logic [3:0]  read_kind;
  logic [63:0] read_start;
  logic [51:0] read_pages;
  logic [63:0] read_attribute;
  logic [6:0]  used_entries;

  modport source (output valid, status, alloc_address, read_kind, read_start, read_pages,
                  read_attribute, used_entries, input ready);
  modport sink   (input valid, status, alloc_address, read_kind, read_start, read_pages,
                  read_attribute, used_entries, output ready);
endinterface

// ===== rtl/mmrt_dp.sv =====
// Datapath: region table memory, scan registers, evaluation stages and result registers.
module mmrt_dp #(
  parameter int unsigned TABLE_DEPTH = mmrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmrt_pkg::dp_op_e    op_i,
  output mmrt_pkg::dp_sts_t   sts_o,
  input  logic [2:0]          action_i,
  input  logic [63:0]         base_address_i,
  input  logic [63:0]         range_length_i,
  input  logic [31:0]         e820_kind_i,
  input  logic [3:0]          mem_kind_i,
  input  logic [51:0]         page_count_i,
  input  logic [63:0]         attribute_i,
  input  logic [5:0]          entry_index_i,
  output logic [1:0]          status_o,
  output logic [63:0]         alloc_address_o,
  output logic [3:0]          read_kind_o,
  output logic [63:0]         read_start_o,
  output logic [51:0]         read_pages_o,
  output logic [63:0]         read_attribute_o,
  output logic [6:0]          used_entries_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW   = $clog2(2 * TABLE_DEPTH + 2);
  localparam int unsigned PS   = mmrt_pkg::PS;
  localparam int unsigned PN_W = mmrt_pkg::PN_W;

  // Table storage
  mmrt_pkg::entry_t mem_q [TABLE_DEPTH];
  mmrt_pkg::entry_t rd_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  mmrt_pkg::entry_t wdata;

  // Control state
  logic [CW-1:0] tot_q, i_q, n_q;
  logic [EW-1:0] est_q;
  logic          stop_q;
  logic [63:0]   ceil_q;

  // Request registers
  logic [2:0]      act_q;
  logic [63:0]     base_q, len_q, attr_q;
  logic [31:0]     fw_q;
  logic [3:0]      kind_q;
  logic [PN_W-1:0] pages_q;
  logic [5:0]      idx_q;
  logic            fr_q;
  logic [63:0]     tstart_q;

  // First evaluation stage
  mmrt_pkg::entry_t e_ent_q;
  logic [63:0]      e_diff_q, e_end_q;
  logic             e_lt_q, e_eq_q, e_free_q;

  // Second evaluation stage
  logic            v_carve_q, v_tail_q, v_exact_q, v_front_q, v_sel_q, v_brk_q, v_cl_q;
  logic [PN_W-1:0] v_cut_q, v_tailpg_q, v_fpg_q;
  logic [63:0]     v_fstart_q;

  // Allocation best candidate
  logic [63:0]      best_start_q, at_q;
  logic [PN_W-1:0]  best_pages_q, rem_q;
  logic [AW-1:0]    best_i_q;
  mmrt_pkg::entry_t best_ent_q;

  // Working and output result
  logic [1:0]       res_status_q;
  logic [63:0]      res_addr_q;
  mmrt_pkg::entry_t res_ent_q;

  logic            idx_ok;
  logic [63:0]     need, pg64, pshift;
  logic [PN_W-1:0] off_up;

  assign idx_ok = (int'(idx_q) < TABLE_DEPTH);
  assign pg64   = {{PS{1'b0}}, e_ent_q.pages};
  assign need   = {{PS{1'b0}}, e_diff_q[63:PS]} + {{PS{1'b0}}, pages_q};
  assign pshift = {pages_q, {PS{1'b0}}};
  assign off_up = PN_W'(!fr_q && (len_q[PS-1:0] != '0));

  // Status to controller
  always_comb begin
    sts_o.action      = act_q;
    sts_o.scan_end    = (i_q >= n_q);
    sts_o.zero_pages  = (pages_q == '0);
    sts_o.exact       = v_exact_q;
    sts_o.tail        = v_tail_q;
    sts_o.brk         = v_brk_q;
    sts_o.add_full    = ((est_q + EW'(!stop_q)) > EW'(TABLE_DEPTH));
    sts_o.found       = (best_start_q != '0);
    sts_o.alloc_exact = (best_pages_q == pages_q);
    sts_o.tab_full    = (tot_q >= CW'(TABLE_DEPTH));
  end

  // Read address
  assign raddr = (op_i == mmrt_pkg::DP_RD_IDX) ? AW'(idx_q) : i_q[AW-1:0];

  // Write port selection
  always_comb begin
    we    = 1'b0;
    waddr = i_q[AW-1:0];
    wdata = e_ent_q;
    case (op_i)
      mmrt_pkg::DP_P2_SLOT: begin
        we = v_carve_q | v_exact_q | v_front_q;
        if (v_carve_q) wdata.pages = v_cut_q;
        if (v_exact_q) begin
          wdata.kind = kind_q;
          wdata.attr = attr_q;
        end
        if (v_front_q) begin
          wdata.start = v_fstart_q;
          wdata.pages = v_fpg_q;
        end
      end
      mmrt_pkg::DP_P2_TAIL: begin
        we    = 1'b1;
        waddr = tot_q[AW-1:0];
        wdata = '{kind: mmrt_pkg::KIND_FREE, start: tstart_q, pages: v_tailpg_q,
                  attr: e_ent_q.attr};
      end
      mmrt_pkg::DP_PUSH_NEW: begin
        we    = 1'b1;
        waddr = tot_q[AW-1:0];
        wdata = '{kind: kind_q, start: base_q, pages: pages_q, attr: attr_q};
      end
      mmrt_pkg::DP_AL_SPLIT: begin
        we          = 1'b1;
        waddr       = best_i_q;
        wdata       = best_ent_q;
        wdata.pages = rem_q;
      end
      mmrt_pkg::DP_AL_PUSH: begin
        we    = 1'b1;
        waddr = tot_q[AW-1:0];
        wdata = '{kind: kind_q, start: at_q, pages: pages_q, attr: attr_q};
      end
      mmrt_pkg::DP_AL_EXACT: begin
        we         = 1'b1;
        waddr      = best_i_q;
        wdata      = best_ent_q;
        wdata.kind = kind_q;
        wdata.attr = attr_q;
      end
      mmrt_pkg::DP_CEIL_ACC: begin
        we         = v_cl_q;
        wdata.kind = mmrt_pkg::KIND_RESERVED;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // Entry count and ceiling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      ceil_q <= mmrt_pkg::CEILING_RESET;
    end else begin
      case (op_i)
        mmrt_pkg::DP_CLEAR: begin
          tot_q  <= '0;
          ceil_q <= mmrt_pkg::CEILING_RESET;
        end
        mmrt_pkg::DP_PREP2: begin
          if (!fr_q && base_q >= mmrt_pkg::LOW_LIMIT && base_q < mmrt_pkg::HIGH_LIMIT &&
              ceil_q > base_q) ceil_q <= base_q;
        end
        mmrt_pkg::DP_P2_TAIL, mmrt_pkg::DP_PUSH_NEW, mmrt_pkg::DP_AL_PUSH: begin
          tot_q <= tot_q + CW'(1);
        end
        default: begin
          tot_q <= tot_q;
        end
      endcase
    end
  end

  // Scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      n_q    <= '0;
      est_q  <= '0;
      stop_q <= 1'b0;
    end else begin
      case (op_i)
        mmrt_pkg::DP_SCAN_INIT: begin
          i_q    <= '0;
          n_q    <= tot_q;
          est_q  <= EW'(tot_q);
          stop_q <= 1'b0;
        end
        mmrt_pkg::DP_P1_ACC: begin
          if (v_tail_q) est_q <= est_q + EW'(1);
          if (v_exact_q) stop_q <= 1'b1;
          else           i_q    <= i_q + CW'(1);
        end
        mmrt_pkg::DP_SCAN_RST: i_q <= '0;
        mmrt_pkg::DP_P2_SLOT, mmrt_pkg::DP_AL_ACC, mmrt_pkg::DP_CEIL_ACC: begin
          i_q <= i_q + CW'(1);
        end
        default: begin
          i_q <= i_q;
        end
      endcase
    end
  end

  // Request capture, e820 rounding, evaluation stages and results
  always_ff @(posedge clk_i) begin
    case (op_i)
      mmrt_pkg::DP_LOAD: begin
        act_q        <= action_i;
        base_q       <= base_address_i;
        len_q        <= range_length_i;
        fw_q         <= e820_kind_i;
        kind_q       <= mem_kind_i;
        pages_q      <= page_count_i;
        attr_q       <= attribute_i;
        idx_q        <= entry_index_i;
        res_status_q <= mmrt_pkg::ST_OK;
        res_addr_q   <= '0;
        res_ent_q    <= '0;
      end
      mmrt_pkg::DP_PREP1: begin
        fr_q <= (fw_q == mmrt_pkg::FW_MEMORY);
        case (fw_q)
          mmrt_pkg::FW_MEMORY: begin
            kind_q <= mmrt_pkg::KIND_FREE;
            attr_q <= mmrt_pkg::ATTR_WB;
          end
          mmrt_pkg::FW_ACPI: begin
            kind_q <= mmrt_pkg::KIND_ACPI;
            attr_q <= mmrt_pkg::ATTR_WB;
          end
          mmrt_pkg::FW_NVS: begin
            kind_q <= mmrt_pkg::KIND_NVS;
            attr_q <= mmrt_pkg::ATTR_UC;
          end
          default: begin
            kind_q <= mmrt_pkg::KIND_RESERVED;
            attr_q <= mmrt_pkg::ATTR_UC;
          end
        endcase
        if (fw_q == mmrt_pkg::FW_MEMORY) begin
          // free memory: move start up to the next page, shorten by the same
          if (base_q[PS-1:0] != '0) begin
            len_q  <= len_q + {{PN_W{1'b0}}, base_q[PS-1:0]} - {{(PN_W-1){1'b0}}, 1'b1,
                      {PS{1'b0}}};
            base_q <= {base_q[63:PS] + PN_W'(1), {PS{1'b0}}};
          end
        end else begin
          len_q  <= len_q + {{PN_W{1'b0}}, base_q[PS-1:0]};
          base_q <= {base_q[63:PS], {PS{1'b0}}};
        end
      end
      mmrt_pkg::DP_PREP2: begin
        pages_q <= len_q[63:PS] + off_up;
      end
      mmrt_pkg::DP_SCAN_INIT: begin
        tstart_q     <= base_q + pshift;
        best_start_q <= '0;
        best_pages_q <= '0;
        best_i_q     <= '0;
      end
      mmrt_pkg::DP_EVA: begin
        e_ent_q  <= rd_q;
        e_diff_q <= base_q - rd_q.start;
        e_lt_q   <= (rd_q.start < base_q);
        e_eq_q   <= (rd_q.start == base_q);
        e_free_q <= (rd_q.kind == mmrt_pkg::KIND_FREE);
        e_end_q  <= rd_q.start + {rd_q.pages, {PS{1'b0}}};
      end
      mmrt_pkg::DP_EVB: begin
        v_carve_q  <= e_free_q && e_lt_q && (pg64 >= need);
        v_tail_q   <= e_free_q && e_lt_q && (pg64 > need);
        v_cut_q    <= e_diff_q[63:PS];
        v_tailpg_q <= PN_W'(pg64 - need);
        v_exact_q  <= e_free_q && e_eq_q && (e_ent_q.pages == pages_q);
        v_front_q  <= e_free_q && e_eq_q && (e_ent_q.pages > pages_q);
        v_fpg_q    <= e_ent_q.pages - pages_q;
        v_fstart_q <= e_ent_q.start + pshift;
        v_sel_q    <= (e_end_q > mmrt_pkg::LOW_LIMIT) && e_free_q &&
                      (e_ent_q.pages >= pages_q) && (e_ent_q.start > best_start_q) &&
                      (e_end_q <= mmrt_pkg::HIGH_LIMIT);
        v_brk_q    <= (e_end_q > mmrt_pkg::LOW_LIMIT) &&
                      (e_ent_q.kind == mmrt_pkg::KIND_RT_CODE ||
                       e_ent_q.kind == mmrt_pkg::KIND_RT_DATA);
        v_cl_q     <= e_free_q && (e_ent_q.start > mmrt_pkg::LOW_LIMIT) &&
                      (e_ent_q.start < mmrt_pkg::HIGH_LIMIT) && (e_ent_q.start >= ceil_q);
      end
      mmrt_pkg::DP_AL_ACC: begin
        if (v_sel_q) begin
          best_start_q <= e_ent_q.start;
          best_pages_q <= e_ent_q.pages;
          best_ent_q   <= e_ent_q;
          best_i_q     <= i_q[AW-1:0];
        end
      end
      mmrt_pkg::DP_AL_REM:      rem_q        <= best_pages_q - pages_q;
      mmrt_pkg::DP_AL_AT:       at_q         <= best_start_q + {rem_q, {PS{1'b0}}};
      mmrt_pkg::DP_AL_PUSH:     res_addr_q   <= at_q;
      mmrt_pkg::DP_AL_EXACT:    res_addr_q   <= best_start_q;
      mmrt_pkg::DP_RD_OUT:      res_ent_q    <= idx_ok ? rd_q : '0;
      mmrt_pkg::DP_SET_FULL:    res_status_q <= mmrt_pkg::ST_FULL;
      mmrt_pkg::DP_SET_NOSPACE: res_status_q <= mmrt_pkg::ST_NOSPACE;
      mmrt_pkg::DP_OUT_LOAD: begin
        status_o         <= res_status_q;
        alloc_address_o  <= res_addr_q;
        read_kind_o      <= res_ent_q.kind;
        read_start_o     <= res_ent_q.start;
        read_pages_o     <= res_ent_q.pages;
        read_attribute_o <= res_ent_q.attr;
        used_entries_o   <= 7'(tot_q);
      end
      default: begin
        act_q <= act_q;
      end
    endcase
  end

  // Checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == mmrt_pkg::DP_P2_TAIL || op_i == mmrt_pkg::DP_PUSH_NEW ||
     op_i == mmrt_pkg::DP_AL_PUSH) |-> tot_q < CW'(TABLE_DEPTH))
    else $error("append with table at capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == mmrt_pkg::DP_CLEAR |=> tot_q == '0 && ceil_q == mmrt_pkg::CEILING_RESET)
    else $error("clear did not reset count and ceiling");

  a_alloc_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == mmrt_pkg::DP_AL_SPLIT || op_i == mmrt_pkg::DP_AL_EXACT) |->
      best_start_q != '0)
    else $error("allocation write without a candidate");

endmodule

// ===== rtl/mmrt_ctrl.sv =====
// Controller: sequences each action over the datapath and runs the channel handshakes.
module mmrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mmrt_pkg::dp_sts_t sts_i,
  output mmrt_pkg::dp_op_e  op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_PREP1, S_PREP2, S_ADDCHK,
    S_P1_RD, S_P1_EVA, S_P1_EVB, S_P1_ACC, S_P1_DEC,
    S_P2_RD, S_P2_EVA, S_P2_EVB, S_P2_SLOT, S_P2_TAIL, S_PUSH,
    S_A_RD, S_A_EVA, S_A_EVB, S_A_ACC, S_A_F1, S_A_F2, S_A_F3, S_A_PUSH,
    S_C_RD, S_C_EVA, S_C_EVB, S_C_ACC, S_R_OUT, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Datapath command for the current state
  always_comb begin
    op_o = mmrt_pkg::DP_NOP;
    case (state_q)
      S_IDLE:   if (in_valid_i) op_o = mmrt_pkg::DP_LOAD;
      S_DISP: begin
        case (sts_i.action)
          mmrt_pkg::ACT_CLEAR: op_o = mmrt_pkg::DP_CLEAR;
          mmrt_pkg::ACT_ALLOC: op_o = mmrt_pkg::DP_SCAN_INIT;
          mmrt_pkg::ACT_CEIL:  op_o = mmrt_pkg::DP_SCAN_INIT;
          mmrt_pkg::ACT_READ:  op_o = mmrt_pkg::DP_RD_IDX;
          default:             op_o = mmrt_pkg::DP_NOP;
        endcase
      end
      S_PREP1:  op_o = mmrt_pkg::DP_PREP1;
      S_PREP2:  op_o = mmrt_pkg::DP_PREP2;
      S_ADDCHK: if (!sts_i.zero_pages) op_o = mmrt_pkg::DP_SCAN_INIT;
      S_P1_EVA, S_P2_EVA, S_A_EVA, S_C_EVA: op_o = mmrt_pkg::DP_EVA;
      S_P1_EVB, S_P2_EVB, S_A_EVB, S_C_EVB: op_o = mmrt_pkg::DP_EVB;
      S_P1_ACC: op_o = mmrt_pkg::DP_P1_ACC;
      S_P1_DEC: op_o = sts_i.add_full ? mmrt_pkg::DP_SET_FULL : mmrt_pkg::DP_SCAN_RST;
      S_P2_SLOT: op_o = mmrt_pkg::DP_P2_SLOT;
      S_P2_TAIL: op_o = mmrt_pkg::DP_P2_TAIL;
      S_PUSH:   op_o = mmrt_pkg::DP_PUSH_NEW;
      S_A_ACC:  op_o = mmrt_pkg::DP_AL_ACC;
      S_A_F1:   op_o = sts_i.found ? mmrt_pkg::DP_AL_REM : mmrt_pkg::DP_SET_NOSPACE;
      S_A_F2:   op_o = mmrt_pkg::DP_AL_AT;
      S_A_F3: begin
        if (sts_i.alloc_exact)   op_o = mmrt_pkg::DP_AL_EXACT;
        else if (sts_i.tab_full) op_o = mmrt_pkg::DP_SET_FULL;
        else                     op_o = mmrt_pkg::DP_AL_SPLIT;
      end
      S_A_PUSH: op_o = mmrt_pkg::DP_AL_PUSH;
      S_C_ACC:  op_o = mmrt_pkg::DP_CEIL_ACC;
      S_R_OUT:  op_o = mmrt_pkg::DP_RD_OUT;
      S_FIN:    if (out_free) op_o = mmrt_pkg::DP_OUT_LOAD;
      default:  op_o = mmrt_pkg::DP_NOP;
    endcase
  end

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISP;
        S_DISP: begin
          case (sts_i.action)
            mmrt_pkg::ACT_E820:  state_q <= S_PREP1;
            mmrt_pkg::ACT_ADD:   state_q <= S_ADDCHK;
            mmrt_pkg::ACT_ALLOC: state_q <= S_A_RD;
            mmrt_pkg::ACT_CEIL:  state_q <= S_C_RD;
            mmrt_pkg::ACT_READ:  state_q <= S_R_OUT;
            default:             state_q <= S_FIN;
          endcase
        end
        S_PREP1:  state_q <= S_PREP2;
        S_PREP2:  state_q <= S_ADDCHK;
        S_ADDCHK: state_q <= sts_i.zero_pages ? S_FIN : S_P1_RD;
        // counting pass
        S_P1_RD:  state_q <= sts_i.scan_end ? S_P1_DEC : S_P1_EVA;
        S_P1_EVA: state_q <= S_P1_EVB;
        S_P1_EVB: state_q <= S_P1_ACC;
        S_P1_ACC: state_q <= sts_i.exact ? S_P1_DEC : S_P1_RD;
        S_P1_DEC: state_q <= sts_i.add_full ? S_FIN : S_P2_RD;
        // writing pass
        S_P2_RD:  state_q <= sts_i.scan_end ? S_PUSH : S_P2_EVA;
        S_P2_EVA: state_q <= S_P2_EVB;
        S_P2_EVB: state_q <= S_P2_SLOT;
        S_P2_SLOT: begin
          if (sts_i.exact)     state_q <= S_FIN;
          else if (sts_i.tail) state_q <= S_P2_TAIL;
          else                 state_q <= S_P2_RD;
        end
        S_P2_TAIL: state_q <= S_P2_RD;
        S_PUSH:    state_q <= S_FIN;
        // allocation scan
        S_A_RD:  state_q <= sts_i.scan_end ? S_A_F1 : S_A_EVA;
        S_A_EVA: state_q <= S_A_EVB;
        S_A_EVB: state_q <= S_A_ACC;
        S_A_ACC: state_q <= sts_i.brk ? S_A_F1 : S_A_RD;
        S_A_F1:  state_q <= sts_i.found ? S_A_F2 : S_FIN;
        S_A_F2:  state_q <= S_A_F3;
        S_A_F3: begin
          if (sts_i.alloc_exact || sts_i.tab_full) state_q <= S_FIN;
          else                                     state_q <= S_A_PUSH;
        end
        S_A_PUSH: state_q <= S_FIN;
        // ceiling scan
        S_C_RD:  state_q <= sts_i.scan_end ? S_FIN : S_C_EVA;
        S_C_EVA: state_q <= S_C_EVB;
        S_C_EVB: state_q <= S_C_ACC;
        S_C_ACC: state_q <= S_C_RD;
        S_R_OUT: state_q <= S_FIN;
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == mmrt_pkg::DP_OUT_LOAD |=> out_valid_q && state_q == S_IDLE)
    else $error("response load did not raise valid");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == mmrt_pkg::DP_LOAD |-> in_ready_o && in_valid_i)
    else $error("request captured outside handshake");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && !out_ready_i |=> state_q == S_FIN)
    else $error("result dropped while output busy");

endmodule

// ===== rtl/memory_map_region_table.sv =====
// Clear, read and unused actions do not scan; ceiling and allocate scan the table at most once,
// and add and e820 run a counting scan and, if there is room, a writing scan that appends
// each carved tail. The table has one read and one write port, and each scanned entry passes
// the two slot evaluation stages. One request is in work at a time.
// Reset clears the entry count and sets the ceiling to 0xFFFFFFFF; slot contents are
// undefined until written, and no clearing pass runs.
module memory_map_region_table #(
  parameter int unsigned TABLE_DEPTH = mmrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmrt_req_if.sink   req_i,
  mmrt_rsp_if.source rsp_o
);

  mmrt_pkg::dp_op_e  op;
  mmrt_pkg::dp_sts_t sts;

  // Sequencer
  mmrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .op_o        (op)
  );

  // Table and arithmetic
  mmrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .sts_o            (sts),
    .action_i         (req_i.action),
    .base_address_i   (req_i.base_address),
    .range_length_i   (req_i.range_length),
    .e820_kind_i      (req_i.e820_kind),
    .mem_kind_i       (req_i.mem_kind),
    .page_count_i     (req_i.page_count),
    .attribute_i      (req_i.attribute),
    .entry_index_i    (req_i.entry_index),
    .status_o         (rsp_o.status),
    .alloc_address_o  (rsp_o.alloc_address),
    .read_kind_o      (rsp_o.read_kind),
    .read_start_o     (rsp_o.read_start),
    .read_pages_o     (rsp_o.read_pages),
    .read_attribute_o (rsp_o.read_attribute),
    .used_entries_o   (rsp_o.used_entries)
  );

endmodule
